/* rtl/plfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package plfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 128;
    localparam int BYTE_W           = 8;
    localparam int CNT_W            = 9;
    localparam int IDX_W            = 7;
    localparam int EV_W             = 3;

    localparam logic [BYTE_W-1:0] PREAMBLE_BYTE  = 8'hFE;
    localparam logic [BYTE_W-1:0] POSTAMBLE_BYTE = 8'hFD;
    localparam logic [CNT_W-1:0]  COUNTER_MAX    = 9'd511;

    typedef enum logic [EV_W-1:0] {
        EV_IGNORED  = 3'd0,
        EV_HUNT     = 3'd1,
        EV_PREAMBLE = 3'd2,
        EV_COMMAND  = 3'd3,
        EV_LENGTH   = 3'd4,
        EV_PAYLOAD  = 3'd5,
        EV_DROPPED  = 3'd6,
        EV_COMPLETE = 3'd7
    } t_event;

    // one byte handed to the deframer core
    typedef struct packed {
        logic              fire;
        logic              enable;
        logic [BYTE_W-1:0] rx_byte;
    } t_step_req;

    // what the core reports for that byte
    typedef struct packed {
        logic              frame_ready;
        logic [BYTE_W-1:0] frame_length;
        logic [BYTE_W-1:0] frame_command;
        logic [IDX_W-1:0]  payload_index;
        logic [BYTE_W-1:0] payload_byte;
        t_event            event_res;
    } t_step_res;

endpackage

`default_nettype wire

/* rtl/plfr_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module plfr_core
    import plfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_step_req i_req,
    output t_step_res      o_res
);

    localparam int POS_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [POS_W-1:0] POS_DEPTH = POS_W'(BUFFER_DEPTH);

    logic              r_in_frame,  n_in_frame;
    logic              r_ready,     n_ready;
    logic [CNT_W-1:0]  r_cnt,       n_cnt;
    logic [BYTE_W-1:0] r_len,       n_len;
    logic [BYTE_W-1:0] r_cmd,       n_cmd;
    logic [POS_W-1:0]  r_pos,       n_pos;
    logic [BYTE_W-1:0] r_prev,      n_prev;

    t_event            ev;
    logic [BYTE_W-1:0] pbyte;
    logic [IDX_W-1:0]  pidx;
    logic [8:0]        pos_ext;
    logic              end_hit;

    assign pos_ext = 9'(r_pos);
    // postamble counts: command + length + len payload bytes already taken
    assign end_hit = (i_req.rx_byte == POSTAMBLE_BYTE) && (r_cnt >= CNT_W'(2))
                     && (r_cnt == (CNT_W'(r_len) + CNT_W'(2)));

    always_comb begin
        n_in_frame = r_in_frame;
        n_ready    = r_ready;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_cmd      = r_cmd;
        n_pos      = r_pos;
        n_prev     = r_prev;
        ev         = EV_IGNORED;
        pbyte      = '0;
        pidx       = '0;
        if (i_req.enable) begin
            if (r_in_frame) begin
                if (end_hit) begin
                    n_pos      = '0;
                    n_ready    = 1'b1;
                    n_in_frame = 1'b0;
                    ev         = EV_COMPLETE;
                end else begin
                    if (r_cnt == CNT_W'(0)) begin
                        n_cmd = i_req.rx_byte;
                        ev    = EV_COMMAND;
                    end else if (r_cnt == CNT_W'(1)) begin
                        n_len = r_len + i_req.rx_byte;
                        ev    = EV_LENGTH;
                    end else if (r_pos < POS_DEPTH) begin
                        pbyte = i_req.rx_byte;
                        pidx  = pos_ext[IDX_W-1:0];
                        n_pos = r_pos + POS_W'(1);
                        ev    = EV_PAYLOAD;
                    end else begin
                        ev = EV_DROPPED;
                    end
                    if (r_cnt != COUNTER_MAX) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end else if ((r_pos != '0) && (i_req.rx_byte == PREAMBLE_BYTE)
                         && (r_prev == PREAMBLE_BYTE)) begin
                n_pos      = '0;
                n_ready    = 1'b0;
                n_in_frame = 1'b1;
                n_cnt      = '0;
                n_len      = '0;
                ev         = EV_PREAMBLE;
            end else begin
                // hunting window wraps to empty when full
                if (r_pos >= POS_DEPTH) begin
                    n_pos = '0;
                end else begin
                    n_prev = i_req.rx_byte;
                    n_pos  = r_pos + POS_W'(1);
                end
                ev = EV_HUNT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_ready    <= 1'b0;
            r_cnt      <= '0;
            r_len      <= '0;
            r_cmd      <= '0;
            r_pos      <= '0;
            r_prev     <= '0;
        end else if (i_req.fire) begin
            r_in_frame <= n_in_frame;
            r_ready    <= n_ready;
            r_cnt      <= n_cnt;
            r_len      <= n_len;
            r_cmd      <= n_cmd;
            r_pos      <= n_pos;
            r_prev     <= n_prev;
        end
    end

    always_comb begin
        o_res.event_res     = ev;
        o_res.payload_byte  = pbyte;
        o_res.payload_index = pidx;
        o_res.frame_command = n_cmd;
        o_res.frame_length  = n_len;
        o_res.frame_ready   = n_ready;
    end

endmodule

`default_nettype wire

/* rtl/preamble_length_frame_receiver_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Deframer for a received serial byte stream of the form
// FE FE CMD LEN DATA[0..LEN-1] FD. Each request on the slave side carries one
// received byte; each byte produces exactly one result on the master side,
// whose tuser tells what happened to it (ignored, hunt, preamble, command,
// length, payload, payload dropped, frame complete) and whose tdata carries
// the payload byte with its buffer index plus the current command, length
// and frame-ready flag. A byte goes through an input register, then one pass
// of decode logic that updates the frame state and fills the output
// register; that step waits while a stalled result holds the output register,
// and a new byte is taken every cycle as long as the master side keeps up.
// Payload bytes past BUFFER_DEPTH are reported as dropped, never stored.
// receive_enable (reset 1): the user must write it through the cfg channel while
// the block is idle (the block does not enforce this). Low, it makes every byte ignored.

module preamble_length_frame_receiver_unit
    import plfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write channel: receive_enable
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] payload_byte, [14:8] payload_index,
                                             // [22:15] frame_command,
                                             // [30:23] frame_length, [31] frame_ready
    output logic [2:0]       m_axis_tuser    // [2:0] event_res
);

    logic              r_rx_en;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_step_res         r_out;
    logic              out_free;
    logic              step_fire;
    t_step_req         step_req;
    t_step_res         step_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_rx_en <= i_cfg_data;
        end
    end

    // output register frees up when empty or being taken this cycle
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step_fire     = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_comb begin
        step_req.fire    = step_fire;
        step_req.enable  = r_rx_en;
        step_req.rx_byte = r_in_byte;
    end

    plfr_core #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (step_req),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.event_res;
    assign m_axis_tdata  = {r_out.frame_ready, r_out.frame_length, r_out.frame_command,
                            r_out.payload_index, r_out.payload_byte};

endmodule

`default_nettype wire

/* rtl/plfr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module plfr_checker
    import plfr_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // payload fields are zero unless the byte was stored as payload
    a_pay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != EV_PAYLOAD) |-> m_axis_tdata[14:0] == 15'd0)
        else $error("payload fields set outside payload");

    // payload only inside an open frame, where frame-ready was cleared
    a_pay_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == EV_PAYLOAD) |-> !m_axis_tdata[31])
        else $error("frame ready during payload");

    // completion raises frame-ready, a preamble drops it
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((m_axis_tuser == EV_COMPLETE) || (m_axis_tuser == EV_PREAMBLE))
            |-> m_axis_tdata[31] == (m_axis_tuser == EV_COMPLETE))
        else $error("frame ready inconsistent with event");

endmodule

bind preamble_length_frame_receiver_unit plfr_checker u_plfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
